// ===== rtl/eqbq_pkg.sv =====
package eqbq_pkg;

    // Coefficient format: signed Q4.28
    localparam int COEF_W    = 32;
    localparam int COEF_FRAC = 28;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_B0 = 3'd0,
        IDX_B1 = 3'd1,
        IDX_B2 = 3'd2,
        IDX_A1 = 3'd3,
        IDX_A2 = 3'd4
    } t_coef_idx;

    // Reset values give a pass-through filter (b0 = 1.0)
    localparam logic [COEF_W-1:0] B0_RESET = 32'h1000_0000;

    // The five normalised coefficients, as seen by the datapath
    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } t_coefs;

endpackage

// ===== rtl/eqbq_coef_regs.sv =====
module eqbq_coef_regs
    import eqbq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [COEF_W-1:0]    i_data,
    output t_coefs               o_coefs
);

    t_coefs r_coefs;

    // Load the addressed coefficient; drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= B0_RESET;
            r_coefs.b1 <= '0;
            r_coefs.b2 <= '0;
            r_coefs.a1 <= '0;
            r_coefs.a2 <= '0;
        end else if (i_we) begin
            unique case (t_coef_idx'(i_index))
                IDX_B0:  r_coefs.b0 <= i_data;
                IDX_B1:  r_coefs.b1 <= i_data;
                IDX_B2:  r_coefs.b2 <= i_data;
                IDX_A1:  r_coefs.a1 <= i_data;
                IDX_A2:  r_coefs.a2 <= i_data;
                default: ;
            endcase
        end
    end

    assign o_coefs = r_coefs;

endmodule

// ===== rtl/eqbq_hist_mem.sv =====
module eqbq_hist_mem #(
    parameter int DEPTH  = 2,
    parameter int WIDTH  = 96,
    parameter int ADDR_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    output logic [WIDTH-1:0]  o_rd_data,
    output logic              o_rd_vld
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_vld;

    // Write port; an entry counts as written from then on
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Registered read; old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    // An entry never written reads as zero history
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;
    assign o_rd_vld  = r_rd_vld;

endmodule

// ===== rtl/eqbq_mac.sv =====
module eqbq_mac
    import eqbq_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  t_coefs                        i_coefs,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [SAMPLE_BITS-1:0] i_x1,
    input  logic signed [SAMPLE_BITS-1:0] i_x2,
    input  logic signed [SAMPLE_BITS-1:0] i_y1,
    input  logic signed [SAMPLE_BITS-1:0] i_y2,
    output logic signed [SAMPLE_BITS-1:0] o_y
);

    localparam int PW = SAMPLE_BITS + COEF_W;
    localparam int SW = PW + 3;
    localparam logic signed [SW-1:0] RND  = SW'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [SW-1:0] SMAX = {{(SW-SAMPLE_BITS+1){1'b0}},
                                             {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = ~SMAX;

    logic signed [PW-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] shifted;

    // Five products in parallel
    assign p_b0 = PW'(i_coefs.b0 * i_x);
    assign p_b1 = PW'(i_coefs.b1 * i_x1);
    assign p_b2 = PW'(i_coefs.b2 * i_x2);
    assign p_a1 = PW'(i_coefs.a1 * i_y1);
    assign p_a2 = PW'(i_coefs.a2 * i_y2);

    // Full-width sum with round-half-up constant
    assign sum = SW'(p_b0) + SW'(p_b1) + SW'(p_b2) - SW'(p_a1) - SW'(p_a2) + RND;

    assign shifted = sum >>> COEF_FRAC;

    // Clamp to the sample range
    always_comb begin
        if (shifted > SMAX) begin
            o_y = SMAX[SAMPLE_BITS-1:0];
        end else if (shifted < SMIN) begin
            o_y = SMIN[SAMPLE_BITS-1:0];
        end else begin
            o_y = shifted[SAMPLE_BITS-1:0];
        end
    end

endmodule

// ===== rtl/peaking_eq_biquad.sv =====
// Channel      Dir  Handshake                    Payload
// s_axis       in   i_s_axis_tvalid/o_s_axis_tready  tdata: sample_in; tuser: channel, first
// m_axis       out  o_m_axis_tvalid/i_m_axis_tready  tdata: sample_out; tuser: channel_out
// cfg          in   i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data (Q4.28)
//
// One item per cycle while the output is not stalled. The history memory reads
// the channel's history word as the item enters the filter stage, which then
// filters, writes the history back and loads the output register. A write
// from the item just ahead is forwarded when both share a channel.
// Reset (synchronous, active low) clears coefficients to pass-through and
// marks all history entries unwritten, which read as zero.
// A stalled output holds the filter stage; input stalls only when both are full.
module peaking_eq_biquad
    import eqbq_pkg::*;
#(
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata, // [SAMPLE_BITS-1:0] sample_in
    input  logic [1:0]               i_s_axis_tuser,   // [0] channel, [1] first
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] o_m_axis_tdata, // [SAMPLE_BITS-1:0] sample_out
    output logic [0:0]               o_m_axis_tuser,   // [0] channel_out
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [COEF_W-1:0]        i_cfg_data
);

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int ADDR_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HIST_W  = 4 * SAMPLE_BITS;
    localparam int SB      = SAMPLE_BITS;

    t_coefs coefs;

    // Input decode
    logic              s_accept;
    logic [ADDR_W-1:0] s_addr;
    logic              b_leave;

    // Filter stage
    logic              r_b_valid;
    logic [SB-1:0]     r_b_x;
    logic [ADDR_W-1:0] r_b_addr;
    logic              r_b_ch;
    logic              r_b_first;
    logic              r_fwd_hit;
    logic [HIST_W-1:0] r_fwd_hist;
    logic [HIST_W-1:0] rd_hist;
    logic              rd_vld;
    logic [HIST_W-1:0] cur_hist;
    logic [HIST_W-1:0] n_hist;
    logic [SB-1:0]     y;

    // Output register
    logic              r_out_valid;
    logic [SB-1:0]     r_out_y;
    logic              r_out_ch;

    assign o_cfg_ready = 1'b1;

    eqbq_coef_regs u_coef_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_coefs (coefs)
    );

    // Channel index wraps onto the history depth
    assign s_addr = (CHANNELS > 1) ? ADDR_W'(i_s_axis_tuser[0]) : '0;

    assign b_leave         = r_b_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_b_valid || b_leave;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    eqbq_hist_mem #(
        .DEPTH  (CHANNELS),
        .WIDTH  (HIST_W),
        .ADDR_W (ADDR_W)
    ) u_hist_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_accept),
        .i_rd_addr (s_addr),
        .i_wr_en   (b_leave),
        .i_wr_addr (r_b_addr),
        .i_wr_data (n_hist),
        .o_rd_data (rd_hist),
        .o_rd_vld  (rd_vld)
    );

    // Advance the filter stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else if (s_accept) begin
            r_b_valid <= 1'b1;
            r_fwd_hit <= b_leave && (r_b_addr == s_addr);
        end else if (b_leave) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_b_x      <= i_s_axis_tdata[SB-1:0];
            r_b_addr   <= s_addr;
            r_b_ch     <= i_s_axis_tuser[0];
            r_b_first  <= i_s_axis_tuser[1];
            r_fwd_hist <= n_hist;
        end
    end

    // Pick history: cleared on first of run, forwarded on back-to-back channel hit
    always_comb begin
        if (r_b_first) begin
            cur_hist = '0;
        end else if (r_fwd_hit) begin
            cur_hist = r_fwd_hist;
        end else begin
            cur_hist = rd_vld ? rd_hist : '0;
        end
    end

    // History word: {x1, x2, y1, y2}
    eqbq_mac #(
        .SAMPLE_BITS (SB)
    ) u_mac (
        .i_coefs (coefs),
        .i_x     (r_b_x),
        .i_x1    (cur_hist[4*SB-1:3*SB]),
        .i_x2    (cur_hist[3*SB-1:2*SB]),
        .i_y1    (cur_hist[2*SB-1:SB]),
        .i_y2    (cur_hist[SB-1:0]),
        .o_y     (y)
    );

    assign n_hist = {r_b_x, cur_hist[4*SB-1:3*SB], y, cur_hist[2*SB-1:SB]};

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_leave) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_leave) begin
            r_out_y  <= y;
            r_out_ch <= r_b_ch;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = TDATA_W'(r_out_y);
    assign o_m_axis_tuser[0] = r_out_ch;

endmodule

// ===== rtl/eqbq_checker.sv =====
module eqbq_checker
    import eqbq_pkg::*;
#(
    parameter int TDATA_W = 24
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [TDATA_W-1:0]   o_m_axis_tdata,
    input logic [0:0]           o_m_axis_tuser
);

    logic       s_acc;
    logic       m_acc;
    logic [2:0] r_inflight;

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc = o_m_axis_tvalid && i_m_axis_tready;

    // Count items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 3'(s_acc) - 3'(m_acc);
        end
    end

    // Never more than the filter stage and the output register
    a_inflight_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'd2)
        else $error("more than two items in flight");

    // An item entering an empty block passes the filter stage, then shows in the output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && r_inflight == 3'd0) |=> ##1 o_m_axis_tvalid)
        else $error("result not delivered two cycles after accept");

    // No result without an item behind it
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> r_inflight != 3'd0)
        else $error("result shown with nothing in flight");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind peaking_eq_biquad eqbq_checker #(
    .TDATA_W (TDATA_W)
) u_eqbq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ===== tb/tb_peaking_eq_biquad.sv =====
module tb_peaking_eq_biquad;
    import eqbq_pkg::*;

    localparam int CHANNELS    = 2;
    localparam int SAMPLE_BITS = 24;
    localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [COEF_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;
    localparam int RANDOM_SETS   = 8;
    localparam int SET_ITEMS     = 240;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_INTERVAL = 700;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          channel;
        logic                          first;
    } t_sample_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          channel;
    } t_sample_out;

    logic i_clk;
    logic rst_n = 1'b0;

    logic                   s_valid   = 1'b0;
    logic [TDATA_W-1:0]     s_tdata   = '0;
    logic [1:0]             s_tuser   = '0;
    logic                   m_ready   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [COEF_W-1:0]      cfg_data  = '0;

    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [TDATA_W-1:0]     o_m_axis_tdata;
    logic [0:0]             o_m_axis_tuser;
    logic                   o_cfg_ready;

    // Filter model state
    t_coefs                        coefs;
    logic signed [SAMPLE_BITS-1:0] hx1 [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] hx2 [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] hy1 [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] hy2 [CHANNELS];

    t_sample_in  sample_feed [$];
    t_sample_out filtered_q  [$];

    t_sample_in cur_item;
    int  gap_left   = 0;
    int  stall_left = 0;
    int  hold_left  = 0;
    bit  drv_calm   = 1'b0;
    bit  mon_calm   = 1'b0;
    int  n_sent     = 0;
    int  n_checked  = 0;
    int  n_sets     = 0;
    int  n_errors   = 0;

    peaking_eq_biquad #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),           // [23:0] sample_in
        .i_s_axis_tuser  (s_tuser),           // [0] channel, [1] first
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),    // [23:0] sample_out
        .o_m_axis_tuser  (o_m_axis_tuser),    // [0] channel_out
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= 20)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Direct form I step: clear history on first, full-width sum, round half up, clamp, shift history
    function automatic t_sample_out filter_sample(input t_sample_in it);
        t_sample_out res;
        longint      acc;
        longint      y;
        int          ch;
        ch = int'(it.channel) % CHANNELS;
        if (it.first) begin
            hx1[ch] = '0;
            hx2[ch] = '0;
            hy1[ch] = '0;
            hy2[ch] = '0;
        end
        acc = longint'(coefs.b0) * longint'(it.sample)
            + longint'(coefs.b1) * longint'(hx1[ch])
            + longint'(coefs.b2) * longint'(hx2[ch])
            - longint'(coefs.a1) * longint'(hy1[ch])
            - longint'(coefs.a2) * longint'(hy2[ch])
            + (longint'(1) <<< (COEF_FRAC - 1));
        y = acc >>> COEF_FRAC;
        if (y > longint'(SMAX))
            y = longint'(SMAX);
        if (y < longint'(SMIN))
            y = longint'(SMIN);
        hx2[ch] = hx1[ch];
        hx1[ch] = it.sample;
        hy2[ch] = hy1[ch];
        hy1[ch] = y[SAMPLE_BITS-1:0];
        res.sample  = y[SAMPLE_BITS-1:0];
        res.channel = it.channel;
        return res;
    endfunction

    function automatic void queue_sample(input logic signed [SAMPLE_BITS-1:0] smp,
                                         input logic ch, input logic clr);
        t_sample_in it;
        it.sample  = smp;
        it.channel = ch;
        it.first   = clr;
        sample_feed.push_back(it);
    endfunction

    function automatic t_sample_in rand_sample();
        t_sample_in it;
        case ($urandom_range(0, 9))
            0:       it.sample = $urandom_range(0, 1) ? SMAX : SMIN;
            1, 2:    it.sample = SAMPLE_BITS'(int'($urandom_range(0, 512)) - 256);
            default: it.sample = SAMPLE_BITS'($urandom);
        endcase
        it.channel = 1'($urandom_range(0, CHANNELS - 1));
        it.first   = ($urandom_range(0, 31) == 0);
        return it;
    endfunction

    function automatic logic [COEF_W-1:0] rand_span(input int span);
        return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Coefficient sets: plausible filters, full range, rails, or small values
    function automatic t_coefs pick_coefs(input int kind);
        t_coefs c;
        case (kind)
            0: begin
                c.b0 = rand_span(1 << 27) + B0_RESET;
                c.b1 = rand_span(1 << 29);
                c.b2 = rand_span(1 << 28);
                c.a1 = rand_span(1 << 29);
                c.a2 = rand_span(1 << 28);
            end
            1: begin
                c.b0 = $urandom;
                c.b1 = $urandom;
                c.b2 = $urandom;
                c.a1 = $urandom;
                c.a2 = $urandom;
            end
            2: begin
                c.b0 = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
                c.b1 = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
                c.b2 = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
                c.a1 = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
                c.a2 = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
            end
            default: begin
                c.b0 = rand_span(1 << 26);
                c.b1 = rand_span(1 << 26);
                c.b2 = rand_span(1 << 26);
                c.a1 = rand_span(1 << 26);
                c.a2 = rand_span(1 << 26);
            end
        endcase
        return c;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            IDX_B0:  coefs.b0 = val;
            IDX_B1:  coefs.b1 = val;
            IDX_B2:  coefs.b2 = val;
            IDX_A1:  coefs.a1 = val;
            IDX_A2:  coefs.a2 = val;
            default: ;
        endcase
    endtask

    // Load all five coefficients plus one write to an unused index
    task automatic load_coefs(input t_coefs c);
        logic [CFG_IDX_W-1:0] bad_idx;
        bad_idx = CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, int'(IDX_A2) + 1));
        cfg_write(IDX_B0, c.b0);
        cfg_write(IDX_B1, c.b1);
        cfg_write(IDX_B2, c.b2);
        cfg_write(IDX_A1, c.a1);
        cfg_write(bad_idx, $urandom);
        cfg_write(IDX_A2, c.a2);
        n_sets++;
    endtask

    // Wait until every queued sample is accepted and every result checked, or the loop gives up;
    // look between edges so the driver's updates have settled
    task automatic wait_drained();
        int k;
        k = 0;
        while ((sample_feed.size() != 0 || s_valid || filtered_q.size() != 0) && k < 20000) begin
            @(negedge i_clk);
            k++;
        end
    endtask

    // Driver: offer queued samples with a random gap after each one
    always @(posedge i_clk) begin
        if (!rst_n) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                filtered_q.push_back(filter_sample(cur_item));
                n_sent++;
            end
            if (!s_valid || o_s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (sample_feed.size() != 0) begin
                    cur_item = sample_feed.pop_front();
                    s_valid <= 1'b1;
                    s_tdata <= TDATA_W'(cur_item.sample);
                    s_tuser <= {cur_item.first, cur_item.channel};
                    if ($urandom_range(0, 99) == 0)
                        drv_calm = !drv_calm;
                    gap_left = drv_calm ? 0 : $urandom_range(0, 9);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result, stall at random, hold off now and then
    always @(posedge i_clk) begin
        t_sample_out want;
        if (!rst_n) begin
            m_ready    <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (o_m_axis_tvalid && m_ready) begin
                if (filtered_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h on channel %0d",
                                              o_m_axis_tdata, o_m_axis_tuser[0]));
                end else begin
                    want = filtered_q.pop_front();
                    if (o_m_axis_tdata[SAMPLE_BITS-1:0] !== want.sample)
                        report_mismatch($sformatf("sample_out %h, expected %h",
                                                  o_m_axis_tdata, want.sample));
                    if (o_m_axis_tuser[0] !== want.channel)
                        report_mismatch($sformatf("channel_out %0d, expected %0d",
                                                  o_m_axis_tuser[0], want.channel));
                end
                n_checked++;
                if (n_checked % HOLD_INTERVAL == 0)
                    hold_left = HOLD_CYCLES;
                if ($urandom_range(0, 99) == 0)
                    mon_calm = !mon_calm;
                stall_left = mon_calm ? 0 : $urandom_range(0, 9);
            end else if (hold_left > 0) begin
                hold_left--;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_ready <= (stall_left == 0 && hold_left == 0);
        end
    end

    // Stimulus
    initial begin
        t_coefs c;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            hx1[ch] = '0;
            hx2[ch] = '0;
            hy1[ch] = '0;
            hy2[ch] = '0;
        end
        coefs    = '0;
        coefs.b0 = B0_RESET;

        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;

        // Pass-through after reset: rails, zero, one LSB either way
        @(negedge i_clk);
        queue_sample(SMAX, 1'b0, 1'b1);
        queue_sample(SMIN, 1'b1, 1'b1);
        queue_sample('0, 1'b0, 1'b0);
        queue_sample(-1, 1'b1, 1'b0);
        queue_sample(1, 1'b0, 1'b0);
        queue_sample(SMAX, 1'b1, 1'b0);
        wait_drained();

        // Half gain: exact ties round toward plus infinity
        c    = '0;
        c.b0 = 32'h0800_0000;
        load_coefs(c);
        @(negedge i_clk);
        queue_sample(1, 1'b0, 1'b1);
        queue_sample(-1, 1'b0, 1'b0);
        queue_sample(3, 1'b1, 1'b1);
        queue_sample(-3, 1'b1, 1'b0);
        wait_drained();

        // Coefficients on the rails: saturate both ways, clear history mid-run
        c.b0 = COEF_MAX;
        c.b1 = COEF_MIN;
        c.b2 = COEF_MAX;
        c.a1 = COEF_MIN;
        c.a2 = COEF_MAX;
        load_coefs(c);
        @(negedge i_clk);
        queue_sample(SMAX, 1'b0, 1'b1);
        queue_sample(SMAX, 1'b0, 1'b0);
        queue_sample(SMIN, 1'b0, 1'b0);
        queue_sample(SMIN, 1'b0, 1'b1);
        queue_sample(SMAX, 1'b1, 1'b1);
        queue_sample(SMIN, 1'b1, 1'b0);
        queue_sample(SMIN, 1'b0, 1'b0);
        wait_drained();

        // Random phases, one coefficient set each
        for (int s = 0; s < RANDOM_SETS; s++) begin
            load_coefs(pick_coefs(s % 4));
            @(negedge i_clk);
            for (int n = 0; n < SET_ITEMS; n++)
                sample_feed.push_back(rand_sample());
            wait_drained();
        end

        // Back to pass-through
        c    = '0;
        c.b0 = B0_RESET;
        load_coefs(c);
        @(negedge i_clk);
        for (int n = 0; n < SET_ITEMS / 3; n++)
            sample_feed.push_back(rand_sample());
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (filtered_q.size() != 0)
            report_mismatch($sformatf("%0d filtered samples never arrived", filtered_q.size()));
        $display("Filtered %0d samples on %0d channels under %0d coefficient sets;",
                 n_sent, CHANNELS, n_sets);
        $display("checked %0d results, with rail saturation, rounding ties and history clears.",
                 n_checked);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial begin
        #(12 * 400000);
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/eqbq_pkg.sv
rtl/eqbq_coef_regs.sv
rtl/eqbq_hist_mem.sv
rtl/eqbq_mac.sv
rtl/peaking_eq_biquad.sv
rtl/eqbq_checker.sv
tb/tb_peaking_eq_biquad.sv
